// ===== hw/rtl/dirm_pkg.sv =====
`timescale 1ns / 1ps

package dirm_pkg;

    localparam int MAX_REGIONS = 256;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int SLOT_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int DIM_W       = 13;
    localparam int END_W       = 14;

    localparam logic [DIM_W-1:0]   SCREEN_MAX = DIM_W'(4096);
    localparam logic [DIM_W-1:0]   SW_RESET   = DIM_W'(1280);
    localparam logic [DIM_W-1:0]   SH_RESET   = DIM_W'(720);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_REGIONS);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_APPEND = 2'd1,
        ST_REJECT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] w;
        logic [12:0] h;
    } t_rect;

    typedef struct packed {
        t_rect               rect;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
        t_status             status;
    } t_result;

endpackage

// ===== hw/rtl/dirty_rect_merge_list.sv =====
// Path per request: reject, clear, op 3, an out-of-range read and an add to an empty list
// go straight from idle to the emit state; a read passes through the read state first; an
// add to a list of n > 0 entries scans it, one RAM read per cycle, until it merges into an
// entry or appends to or finds full the list. One request in work at a time: the next is
// taken once the result word is registered and the block is idle (later while output stalls).
// Reset (sync, active low): list empty, screen 1280 x 720, no word out; RAM not cleared.
`timescale 1ns / 1ps

module dirty_rect_merge_list
    import dirm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic signed [15:0]        i_rect_x,
    input  logic signed [15:0]        i_rect_y,
    input  logic [14:0]               i_rect_w,
    input  logic [14:0]               i_rect_h,
    input  logic [7:0]                i_read_index,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [11:0]               o_out_x,
    output logic [11:0]               o_out_y,
    output logic [12:0]               o_out_w,
    output logic [12:0]               o_out_h,
    output logic [7:0]                o_slot,
    output logic [8:0]                o_entry_count,
    output logic [1:0]                o_status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    function automatic logic [DIM_W-1:0] screen_dim(logic [DIM_W-1:0] value);
        return (value > SCREEN_MAX) ? SCREEN_MAX : value;
    endfunction

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DIM_W-1:0]    r_sw, n_sw;
    logic [DIM_W-1:0]    r_sh, n_sh;
    t_rect               r_rect, n_rect;
    logic [END_W-1:0]    r_x_end, n_x_end;
    logic [END_W-1:0]    r_y_end, n_y_end;
    logic [IDX_W-1:0]    r_rd_addr, n_rd_addr;
    logic                r_issue, n_issue;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]    r_last_idx, n_last_idx;
    t_result             r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_rect               ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [$bits(t_rect)-1:0] ram_rdata;

    logic signed [17:0]  c_sw, c_sh, c_x, c_y, c_x_end, c_y_end;
    logic signed [17:0]  c_xc, c_yc, c_xe, c_ye;
    logic                c_reject;
    t_rect               c_rect;

    t_rect               s_old, s_merge;
    logic [END_W-1:0]    s_ox_end, s_oy_end, s_mx, s_my, s_mx_end, s_my_end;
    logic                s_hit;

    logic                in_acc;

    dirm_ram #(
        .WIDTH ($bits(t_rect)),
        .DEPTH (MAX_REGIONS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {19'b0, r_sh} : {19'b0, r_sw};

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // clamp against the screen, tested on the raw edges
    always_comb begin
        c_sw     = $signed({5'b0, screen_dim(r_sw)});
        c_sh     = $signed({5'b0, screen_dim(r_sh)});
        c_x      = 18'(i_rect_x);
        c_y      = 18'(i_rect_y);
        c_x_end  = c_x + $signed({3'b0, i_rect_w});
        c_y_end  = c_y + $signed({3'b0, i_rect_h});
        c_reject = (c_x_end < 0) || (c_y_end < 0) || (c_x >= c_sw) || (c_y >= c_sh);
        c_xc     = (c_x < 0) ? 18'sd0 : c_x;
        c_yc     = (c_y < 0) ? 18'sd0 : c_y;
        c_xe     = (c_x_end > c_sw) ? c_sw : c_x_end;
        c_ye     = (c_y_end > c_sh) ? c_sh : c_y_end;
        c_rect.x = c_xc[11:0];
        c_rect.y = c_yc[11:0];
        c_rect.w = 13'(c_xe - c_xc);
        c_rect.h = 13'(c_ye - c_yc);
    end

    // overlap (edges inclusive) and bounding box against the entry just read
    always_comb begin
        s_old    = t_rect'(ram_rdata);
        s_ox_end = END_W'(s_old.x) + END_W'(s_old.w);
        s_oy_end = END_W'(s_old.y) + END_W'(s_old.h);
        s_hit    = !((END_W'(s_old.x) > r_x_end) || (s_ox_end < END_W'(r_rect.x)) ||
                     (END_W'(s_old.y) > r_y_end) || (s_oy_end < END_W'(r_rect.y)));
        s_mx     = (s_old.x < r_rect.x) ? END_W'(s_old.x) : END_W'(r_rect.x);
        s_my     = (s_old.y < r_rect.y) ? END_W'(s_old.y) : END_W'(r_rect.y);
        s_mx_end = (s_ox_end > r_x_end) ? s_ox_end : r_x_end;
        s_my_end = (s_oy_end > r_y_end) ? s_oy_end : r_y_end;
        s_merge.x = s_mx[11:0];
        s_merge.y = s_my[11:0];
        s_merge.w = 13'(s_mx_end - s_mx);
        s_merge.h = 13'(s_my_end - s_my);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sw        = r_sw;
        n_sh        = r_sh;
        n_rect      = r_rect;
        n_x_end     = r_x_end;
        n_y_end     = r_y_end;
        n_rd_addr   = r_rd_addr;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_last_idx  = r_last_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_pend_idx;
        ram_wdata   = s_merge;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_addr;

        if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                n_sh = pwdata[DIM_W-1:0];
            end else begin
                n_sw = pwdata[DIM_W-1:0];
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res        = '0;
                    n_res.count  = COUNT_W'(r_count);
                    n_res.status = ST_DONE;
                    n_state      = S_EMIT;
                    case (t_op'(i_op))
                        OP_ADD: begin
                            n_rect  = c_rect;
                            n_x_end = c_xe[END_W-1:0];
                            n_y_end = c_ye[END_W-1:0];
                            if (c_reject) begin
                                n_res.status = ST_REJECT;
                            end else if (r_count == '0) begin
                                ram_we       = 1'b1;
                                ram_waddr    = '0;
                                ram_wdata    = c_rect;
                                n_count      = CNT_W'(1);
                                n_res.rect   = c_rect;
                                n_res.count  = COUNT_W'(1);
                                n_res.status = ST_APPEND;
                            end else begin
                                n_rd_addr  = '0;
                                n_issue    = 1'b1;
                                n_last_idx = IDX_W'(r_count - CNT_W'(1));
                                n_state    = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            n_res.slot = SLOT_W'(i_read_index);
                            if (13'(i_read_index) < 13'(r_count)) begin
                                ram_re    = 1'b1;
                                ram_raddr = IDX_W'(i_read_index);
                                n_state   = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_res.count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_re     = r_issue;
                n_pend     = r_issue;
                n_pend_idx = r_rd_addr;
                if (r_rd_addr == r_last_idx) begin
                    n_issue = 1'b0;
                end else begin
                    n_rd_addr = r_rd_addr + IDX_W'(1);
                end
                if (r_pend) begin
                    if (s_hit) begin
                        ram_we       = 1'b1;
                        n_res.rect   = s_merge;
                        n_res.slot   = SLOT_W'(r_pend_idx);
                        n_res.status = ST_DONE;
                        n_issue      = 1'b0;
                        n_pend       = 1'b0;
                        n_state      = S_EMIT;
                    end else if (r_pend_idx == r_last_idx) begin
                        n_res.rect = r_rect;
                        n_issue    = 1'b0;
                        n_pend     = 1'b0;
                        n_state    = S_EMIT;
                        if (r_count == CNT_W'(MAX_REGIONS)) begin
                            n_res.slot   = '0;
                            n_res.status = ST_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            ram_waddr    = IDX_W'(r_count);
                            ram_wdata    = r_rect;
                            n_count      = r_count + CNT_W'(1);
                            n_res.slot   = SLOT_W'(r_count);
                            n_res.count  = COUNT_W'(r_count + CNT_W'(1));
                            n_res.status = ST_APPEND;
                        end
                    end
                end
            end
            S_READ: begin
                n_res.rect = t_rect'(ram_rdata);
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sw        <= SW_RESET;
            r_sh        <= SH_RESET;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sw        <= n_sw;
            r_sh        <= n_sh;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rect     <= n_rect;
        r_x_end    <= n_x_end;
        r_y_end    <= n_y_end;
        r_rd_addr  <= n_rd_addr;
        r_pend_idx <= n_pend_idx;
        r_last_idx <= n_last_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out.rect.x;
    assign o_out_y       = r_out.rect.y;
    assign o_out_w       = r_out.rect.w;
    assign o_out_h       = r_out.rect.h;
    assign o_slot        = r_out.slot;
    assign o_entry_count = r_out.count;
    assign o_status      = r_out.status;

endmodule

// ===== hw/rtl/dirm_ram.sv =====
`timescale 1ns / 1ps

module dirm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/dirm_checker.sv =====
`timescale 1ns / 1ps

module dirm_checker
    import dirm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [11:0] o_out_x,
    input  logic [11:0] o_out_y,
    input  logic [12:0] o_out_w,
    input  logic [12:0] o_out_h,
    input  logic [7:0]  o_slot,
    input  logic [8:0]  o_entry_count,
    input  logic [1:0]  o_status
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_x) &&
        $stable(o_out_y) && $stable(o_out_w) && $stable(o_out_h) &&
        $stable(o_slot) && $stable(o_entry_count) && $stable(o_status))
        else $error("stalled result word changed");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a request is in work");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_REJECT) |->
        (o_out_x == '0) && (o_out_y == '0) && (o_out_w == '0) && (o_out_h == '0) &&
        (o_slot == '0))
        else $error("rejected word carries a rectangle");

    a_append_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_APPEND) |->
        (o_entry_count == (9'(o_slot) + 9'd1)))
        else $error("append slot does not match entry count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |->
        (o_entry_count == COUNT_FULL) && (o_slot == '0))
        else $error("full status with list not full");

endmodule

bind dirty_rect_merge_list dirm_checker u_dirm_checker (.*);

// ===== tb/dirty_rect_merge_list_test.sv =====
`timescale 1ns / 1ps

module dirty_rect_merge_list_test;
    import dirm_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [2:0] ADDR_SCREEN_W   = 3'd0;
    localparam logic [2:0] ADDR_SCREEN_H   = 3'd4;
    localparam int         CYCLE_LIMIT     = 1_500_000;
    localparam int         LONG_HOLD       = 400;
    localparam int         PHASE_ITEMS     = 55;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [7:0]         idx;
    } req_t;

    class region_scoreboard;
        int      scr_w;
        int      scr_h;
        int      box_x[MAX_REGIONS];
        int      box_y[MAX_REGIONS];
        int      box_w[MAX_REGIONS];
        int      box_h[MAX_REGIONS];
        int      stored;
        int      errors;
        t_result pending[$];

        function new();
            scr_w  = SW_RESET;
            scr_h  = SH_RESET;
            stored = 0;
            errors = 0;
        endfunction

        function void set_screen(logic [2:0] addr, int value);
            if (addr == ADDR_SCREEN_W) scr_w = value & 'h1FFF;
            else scr_h = value & 'h1FFF;
        endfunction

        function void note_request(req_t r);
            int sw, sh, x, y, w, h, i, hit, mx, my, mw, mh;
            t_result res;
            res = '0;
            res.status = ST_DONE;
            case (r.op)
                OP_ADD: begin
                    sw = (scr_w > 4096) ? 4096 : scr_w;
                    sh = (scr_h > 4096) ? 4096 : scr_h;
                    x = r.x;
                    y = r.y;
                    w = r.w;
                    h = r.h;
                    if (x + w < 0 || y + h < 0 || x >= sw || y >= sh) begin
                        res.status = ST_REJECT;
                    end else begin
                        if (x < 0) begin
                            w = w + x;
                            x = 0;
                        end
                        if (y < 0) begin
                            h = h + y;
                            y = 0;
                        end
                        if (x + w > sw) w = sw - x;
                        if (y + h > sh) h = sh - y;
                        hit = -1;
                        for (i = 0; i < stored && hit < 0; i++) begin
                            if (!(box_x[i] > x + w || box_x[i] + box_w[i] < x ||
                                  box_y[i] > y + h || box_y[i] + box_h[i] < y))
                                hit = i;
                        end
                        if (hit >= 0) begin
                            mx = (box_x[hit] < x) ? box_x[hit] : x;
                            my = (box_y[hit] < y) ? box_y[hit] : y;
                            mw = ((box_x[hit] + box_w[hit] > x + w) ?
                                  box_x[hit] + box_w[hit] : x + w) - mx;
                            mh = ((box_y[hit] + box_h[hit] > y + h) ?
                                  box_y[hit] + box_h[hit] : y + h) - my;
                            box_x[hit] = mx;
                            box_y[hit] = my;
                            box_w[hit] = mw;
                            box_h[hit] = mh;
                            x = mx;
                            y = my;
                            w = mw;
                            h = mh;
                            res.slot = 8'(hit);
                            res.status = ST_DONE;
                        end else if (stored >= MAX_REGIONS) begin
                            res.status = ST_FULL;
                        end else begin
                            box_x[stored] = x;
                            box_y[stored] = y;
                            box_w[stored] = w;
                            box_h[stored] = h;
                            res.slot = 8'(stored);
                            stored++;
                            res.status = ST_APPEND;
                        end
                        res.rect.x = 12'(x);
                        res.rect.y = 12'(y);
                        res.rect.w = 13'(w);
                        res.rect.h = 13'(h);
                    end
                end
                OP_READ: begin
                    res.slot = r.idx;
                    if (r.idx < stored) begin
                        res.rect.x = 12'(box_x[r.idx]);
                        res.rect.y = 12'(box_y[r.idx]);
                        res.rect.w = 13'(box_w[r.idx]);
                        res.rect.h = 13'(box_h[r.idx]);
                    end
                end
                OP_CLEAR: stored = 0;
                default: ;
            endcase
            res.count = 9'(stored);
            pending.push_back(res);
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, got x=%0d y=%0d w=%0d h=%0d slot=%0d status=%0d",
                         $time, got.rect.x, got.rect.y, got.rect.w, got.rect.h, got.slot,
                         got.status);
                return;
            end
            want = pending.pop_front();
            check_field("out_x", want.rect.x, got.rect.x);
            check_field("out_y", want.rect.y, got.rect.y);
            check_field("out_w", want.rect.w, got.rect.w);
            check_field("out_h", want.rect.h, got.rect.h);
            check_field("slot", want.slot, got.slot);
            check_field("entry_count", want.count, got.count);
            check_field("status", want.status, got.status);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_op;
    logic signed [15:0] i_rect_x;
    logic signed [15:0] i_rect_y;
    logic [14:0]        i_rect_w;
    logic [14:0]        i_rect_h;
    logic [7:0]         i_read_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [11:0]        o_out_x;
    logic [11:0]        o_out_y;
    logic [12:0]        o_out_w;
    logic [12:0]        o_out_h;
    logic [7:0]         o_slot;
    logic [8:0]         o_entry_count;
    logic [1:0]         o_status;

    region_scoreboard book;
    bit               idle_on;
    bit               long_hold_req;
    int               cycles;

    dirty_rect_merge_list DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_w      (i_rect_w),
        .i_rect_h      (i_rect_h),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_w       (o_out_w),
        .o_out_h       (o_out_h),
        .o_slot        (o_slot),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic req_t mk(logic [1:0] op, int x, int y, int w, int h, int idx);
        req_t r;
        r.op  = op;
        r.x   = 16'(x);
        r.y   = 16'(y);
        r.w   = 15'(w);
        r.h   = 15'(h);
        r.idx = 8'(idx);
        return r;
    endfunction

    function automatic req_t rand_req(int sw, int sh, int count_now);
        req_t r;
        int   pick;
        int   ew, eh;
        ew = (sw > 4096) ? 4096 : sw;
        eh = (sh > 4096) ? 4096 : sh;
        r = mk(OP_ADD, $urandom, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            r.x = 16'(int'($urandom_range(0, ew + 16)) - 8);
            r.y = 16'(int'($urandom_range(0, eh + 16)) - 8);
            r.w = 15'($urandom_range(0, ew / 4 + 2));
            r.h = 15'($urandom_range(0, eh / 4 + 2));
        end else if (pick < 70) begin
            r.op = OP_ADD;
        end else if (pick < 90) begin
            r.op = OP_READ;
            if ($urandom_range(0, 3) != 0) r.idx = 8'($urandom_range(0, count_now + 1));
        end else if (pick < 95) begin
            r.op = OP_CLEAR;
        end else begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(req_t r);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op         <= r.op;
        i_rect_x     <= r.x;
        i_rect_y     <= r.y;
        i_rect_w     <= r.w;
        i_rect_h     <= r.h;
        i_read_index <= r.idx;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        book.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        book.set_screen(addr, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_screen(int sw, int sh);
        drain();
        apb_write(ADDR_SCREEN_W, sw);
        apb_write(ADDR_SCREEN_H, sh);
    endtask

    // result side
    initial begin
        t_result got;
        int      hold;
        i_out_stall = 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.rect.x = o_out_x;
                got.rect.y = o_out_y;
                got.rect.w = o_out_w;
                got.rect.h = o_out_h;
                got.slot   = o_slot;
                got.count  = o_entry_count;
                got.status = t_status'(o_status);
                book.check_result(got);
                hold = idle_on ? $urandom_range(0, 5) : 0;
            end
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            @(negedge i_clk);
            i_out_stall <= (hold > 0);
            if (hold > 0) hold--;
        end
    end

    initial begin
        int phase_w[7] = '{64, 4096, 1, 8191, 0, 300, 200};
        int phase_h[7] = '{48, 4096, 1, 6000, 300, 0, 150};
        int p, k;
        book = new();
        cycles        = 0;
        idle_on       = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_op          = OP_ADD;
        i_rect_x      = '0;
        i_rect_y      = '0;
        i_rect_w      = '0;
        i_rect_h      = '0;
        i_read_index  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset screen 1280 x 720
        send_item(mk(OP_ADD, 0, 0, 0, 0, 0));
        send_item(mk(OP_ADD, -10, -10, 10, 10, 0));
        send_item(mk(OP_ADD, -32768, 5, 32767, 5, 0));
        send_item(mk(OP_ADD, 100, -32768, 5, 32767, 0));
        send_item(mk(OP_ADD, 1280, 0, 5, 5, 0));
        send_item(mk(OP_ADD, 0, 720, 5, 5, 0));
        send_item(mk(OP_ADD, 32767, 32767, 32767, 32767, 255));
        send_item(mk(OP_ADD, 1279, 719, 32767, 32767, 0));
        send_item(mk(OP_ADD, -100, -100, 32767, 32767, 0));
        send_item(mk(OP_ADD, 500, 500, 10, 10, 0));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 0));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 1));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 2));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 255));
        send_item(mk(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom));
        send_item(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 0));
        send_item(mk(OP_ADD, 10, 10, 10, 10, 0));
        send_item(mk(OP_ADD, 20, 10, 5, 5, 0));
        send_item(mk(OP_ADD, 26, 10, 5, 5, 0));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 1));
        send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0));

        // random phases over several screen sizes
        for (p = 0; p < 7; p++) begin
            set_screen(phase_w[p], phase_h[p]);
            idle_on = ($urandom_range(0, 3) != 0);
            if (p == 0) begin
                // receiver holds off while requests keep coming
                long_hold_req = 1'b1;
                for (k = 0; k < 20; k++)
                    send_item(rand_req(book.scr_w, book.scr_h, book.stored));
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) idle_on = ~idle_on;
                send_item(rand_req(book.scr_w, book.scr_h, book.stored));
            end
        end

        // fill the list with separated boxes, then overflow it
        set_screen(4096, 4096);
        idle_on = ($urandom_range(0, 1) != 0);
        send_item(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        for (k = 0; k < MAX_REGIONS; k++)
            send_item(mk(OP_ADD, 16 * (k % 16), 16 * (k / 16), $urandom_range(0, 3),
                         $urandom_range(0, 3), $urandom));
        for (k = 0; k < 5; k++)
            send_item(mk(OP_ADD, 3000 + 16 * k, 3000, 2, 2, $urandom));
        send_item(mk(OP_ADD, 242, 242, 4, 4, $urandom));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 255));
        send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, 0));
        for (k = 0; k < 10; k++)
            send_item(mk(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom));
        send_item(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));

        drain();
        repeat (300) @(posedge i_clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
